@@ sv/wcss_pkg.sv @@
// Shared types and constants for the weighted capacity sorted set.
`default_nettype none
package wcss_pkg;

	localparam int ID_W            = 32;
	localparam int SIZE_W          = 16;
	localparam int POS_W           = 4;
	localparam int OP_W            = 2;
	localparam int STATUS_W        = 3;
	localparam int COUNT_W         = 5;
	localparam int MAX_ENTRIES_DEF = 16;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET    = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_ROOM   = 3'd1,
		ST_DUP       = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
	} slot_t;

	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [ID_W-1:0]   key;
		logic [SIZE_W-1:0] size;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ sv/wcss_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none
module wcss_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire wcss_pkg::cell_ctrl_t ctrl,
	input  wire wcss_pkg::slot_t      left_slot,
	input  wire                       left_lt,
	input  wire wcss_pkg::slot_t      right_slot,
	output wcss_pkg::slot_t           slot,
	output logic                      lt,
	output logic                      eq
);
	import wcss_pkg::*;

	slot_t slot_q;
	slot_t slot_d;

	assign lt   = slot_q.valid && (slot_q.id < ctrl.key);
	assign eq   = slot_q.valid && (slot_q.id == ctrl.key);
	assign slot = slot_q;

	// insert: cells below the key hold, the first cell at or above takes the new
	// word, the rest take their left neighbor; remove: cells at or above pull right
	always_comb begin
		slot_d = slot_q;
		if (ctrl.ins && !lt) begin
			if (left_lt) begin
				slot_d.valid = 1'b1;
				slot_d.id    = ctrl.key;
				slot_d.size  = ctrl.size;
			end else begin
				slot_d = left_slot;
			end
		end else if (ctrl.rem && slot_q.valid && !lt) begin
			slot_d = right_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/weighted_capacity_sorted_set_unit.sv @@
// Top level of the weighted capacity sorted set.
// Entries (id, size) sit in a row of MAX_ENTRIES cells kept in ascending id
// order; every cell compares its id with the incoming key in the same cycle,
// so an append, remove or get is decided and applied in the cycle the input
// word is accepted. The result word lands in an output register and shows in
// the cycle after; a new input word is taken every cycle while that register
// is empty or being drained, so the block sustains one operation per cycle.
// The capacity register is written through cfg_we/cfg_wdata and takes effect
// for the next accepted word. Reset clears all slots, fill and count at once.
`default_nettype none
module weighted_capacity_sorted_set_unit #(
	parameter int MAX_ENTRIES = wcss_pkg::MAX_ENTRIES_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire  [wcss_pkg::SIZE_W-1:0]   cfg_wdata,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [wcss_pkg::OP_W-1:0]     operation,
	input  wire  [wcss_pkg::ID_W-1:0]     cell_id,
	input  wire  [wcss_pkg::SIZE_W-1:0]   cell_size,
	input  wire  [wcss_pkg::POS_W-1:0]    position,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [wcss_pkg::STATUS_W-1:0] status,
	output logic [wcss_pkg::ID_W-1:0]     found_id,
	output logic [wcss_pkg::SIZE_W-1:0]   found_size,
	output logic [wcss_pkg::SIZE_W-1:0]   fill_level,
	output logic [wcss_pkg::COUNT_W-1:0]  entry_count
);
	import wcss_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	slot_t             slots [MAX_ENTRIES];
	logic              lt_v  [MAX_ENTRIES];
	logic              eq_v  [MAX_ENTRIES];
	cell_ctrl_t        ctrl;
	logic              accept;
	logic              hit;
	logic [SIZE_W-1:0] hit_size;
	logic [ID_W-1:0]   rd_id;
	logic [SIZE_W-1:0] rd_size;
	logic              over;
	logic              full;
	logic              in_range;

	logic [SIZE_W-1:0] capacity_q;
	logic [SIZE_W-1:0] fill_q;
	logic [SIZE_W-1:0] fill_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_d;
	status_t           status_d;
	logic [ID_W-1:0]   got_id;
	logic [SIZE_W-1:0] got_size;

	logic              out_valid_q;
	status_t           status_q;
	logic [ID_W-1:0]   found_id_q;
	logic [SIZE_W-1:0] found_size_q;
	logic [SIZE_W-1:0] fill_level_q;
	logic [CNT_W-1:0]  count_out_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
			slot_t lslot;
			slot_t rslot;
			logic  llt;
			if (gi == 0) begin : g_first
				assign lslot = '0;
				assign llt   = 1'b1;
			end else begin : g_mid
				assign lslot = slots[gi-1];
				assign llt   = lt_v[gi-1];
			end
			if (gi == MAX_ENTRIES - 1) begin : g_last
				assign rslot = '0;
			end else begin : g_inner
				assign rslot = slots[gi+1];
			end
			wcss_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.left_slot  (lslot),
				.left_lt    (llt),
				.right_slot (rslot),
				.slot       (slots[gi]),
				.lt         (lt_v[gi]),
				.eq         (eq_v[gi])
			);
		end
	endgenerate

	// match and position read, AND-OR across the row
	always_comb begin
		hit      = 1'b0;
		hit_size = '0;
		rd_id    = '0;
		rd_size  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			hit = hit | eq_v[i];
			if (eq_v[i]) begin
				hit_size = hit_size | slots[i].size;
			end
			if (i == int'(position)) begin
				rd_id   = rd_id | slots[i].id;
				rd_size = rd_size | slots[i].size;
			end
		end
	end

	assign over     = ({1'b0, fill_q} + {1'b0, cell_size}) > {1'b0, capacity_q};
	assign full     = (count_q == CNT_W'(MAX_ENTRIES));
	assign in_range = (32'(position) < 32'(count_q));

	always_comb begin
		status_d  = ST_OK;
		got_id    = '0;
		got_size  = '0;
		fill_d    = fill_q;
		count_d   = count_q;
		ctrl.ins  = 1'b0;
		ctrl.rem  = 1'b0;
		ctrl.key  = cell_id;
		ctrl.size = cell_size;
		case (operation)
			OP_APPEND: begin
				if (over) begin
					status_d = ST_NO_ROOM;
				end else if (hit) begin
					status_d = ST_DUP;
				end else if (full) begin
					status_d = ST_NO_ROOM;
				end else begin
					ctrl.ins = accept;
					fill_d   = fill_q + cell_size;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (!hit) begin
					status_d = ST_NOT_FOUND;
				end else begin
					ctrl.rem = accept;
					fill_d   = fill_q - hit_size;
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_GET: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					got_id   = rd_id;
					got_size = rd_size;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= '0;
			fill_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (accept) begin
				fill_q      <= fill_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			found_id_q   <= got_id;
			found_size_q <= got_size;
			fill_level_q <= fill_d;
			count_out_q  <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_id    = found_id_q;
	assign found_size  = found_size_q;
	assign fill_level  = fill_level_q;
	assign entry_count = COUNT_W'(count_out_q);

endmodule
`default_nettype wire

@@ sv/wcss_chk.sv @@
// Port-level checks for the weighted capacity sorted set, bound to the top level.
`default_nettype none
module wcss_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire [wcss_pkg::STATUS_W-1:0]  status,
	input wire [wcss_pkg::ID_W-1:0]      found_id,
	input wire [wcss_pkg::SIZE_W-1:0]    found_size,
	input wire [wcss_pkg::SIZE_W-1:0]    fill_level,
	input wire [wcss_pkg::COUNT_W-1:0]   entry_count
);
	import wcss_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_level)
			&& $stable(entry_count) && $stable(found_id))
		else $error("result word changed while stalled");

	// every accepted word yields a result on the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted word gave no result");

	// found fields only carry data on a successful get
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> found_id == '0 && found_size == '0)
		else $error("found fields set on failed operation");

	// an empty set holds no weight
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_count == '0 |-> fill_level == '0)
		else $error("fill nonzero with no entries");

endmodule

bind weighted_capacity_sorted_set_unit wcss_chk u_wcss_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found_id    (found_id),
	.found_size  (found_size),
	.fill_level  (fill_level),
	.entry_count (entry_count)
);
`default_nettype wire

@@ tb/weighted_capacity_sorted_set_unit_test.sv @@
// Self-checking testbench for the weighted capacity sorted set: random-gap driver, stalling checker.
`timescale 1ns / 100ps
module weighted_capacity_sorted_set_unit_test;
	import wcss_pkg::*;

	localparam int SLOTS       = MAX_ENTRIES_DEF;
	localparam int ID_POOL     = 24;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 120;
	localparam int QUIET_LIMIT = 2000;
	localparam int SHOW_LIMIT  = 10;

	// operation code the block does not define; must act as a no-op
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
		logic [POS_W-1:0]  pos;
	} set_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     id;
		logic [SIZE_W-1:0]   size;
		logic [SIZE_W-1:0]   fill;
		logic [COUNT_W-1:0]  count;
	} set_reply_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [SIZE_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [OP_W-1:0]     operation = '0;
	logic [ID_W-1:0]     cell_id = '0;
	logic [SIZE_W-1:0]   cell_size = '0;
	logic [POS_W-1:0]    position = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     found_id;
	logic [SIZE_W-1:0]   found_size;
	logic [SIZE_W-1:0]   fill_level;
	logic [COUNT_W-1:0]  entry_count;

	weighted_capacity_sorted_set_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.cell_id     (cell_id),
		.cell_size   (cell_size),
		.position    (position),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_id    (found_id),
		.found_size  (found_size),
		.fill_level  (fill_level),
		.entry_count (entry_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// shadow copy of the set, kept sorted by id
	logic [ID_W-1:0]   shadow_ids [SLOTS];
	logic [SIZE_W-1:0] shadow_sizes [SLOTS];
	int                shadow_count = 0;
	logic [SIZE_W-1:0] shadow_fill = '0;
	logic [SIZE_W-1:0] shadow_capacity = '0;

	set_cmd_t   pending_ops [$];
	set_reply_t predicted_replies [$];
	logic [ID_W-1:0] id_pool [ID_POOL];

	set_cmd_t cur_cmd = '0;
	int gap_left = 0;
	int words_sent = 0;
	int ready_wait = 0;
	int replies_seen = 0;
	int error_count = 0;

	task automatic predict_reply(input set_cmd_t c);
		set_reply_t r;
		int slot;
		bit dup;
		r = '0;
		r.status = ST_OK;
		case (c.op)
			OP_APPEND: begin
				dup = 1'b0;
				slot = 0;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_ids[i] == c.id)
						dup = 1'b1;
					if (shadow_ids[i] < c.id)
						slot++;
				end
				if (int'(shadow_fill) + int'(c.size) > int'(shadow_capacity))
					r.status = ST_NO_ROOM;
				else if (dup)
					r.status = ST_DUP;
				else if (shadow_count >= SLOTS)
					r.status = ST_NO_ROOM;
				else begin
					for (int i = shadow_count; i > slot; i--) begin
						shadow_ids[i] = shadow_ids[i-1];
						shadow_sizes[i] = shadow_sizes[i-1];
					end
					shadow_ids[slot] = c.id;
					shadow_sizes[slot] = c.size;
					shadow_fill = shadow_fill + c.size;
					shadow_count++;
				end
			end
			OP_REMOVE: begin
				slot = shadow_count;
				for (int i = 0; i < shadow_count; i++)
					if (shadow_ids[i] == c.id)
						slot = i;
				if (slot >= shadow_count)
					r.status = ST_NOT_FOUND;
				else begin
					shadow_fill = shadow_fill - shadow_sizes[slot];
					for (int i = slot; i + 1 < shadow_count; i++) begin
						shadow_ids[i] = shadow_ids[i+1];
						shadow_sizes[i] = shadow_sizes[i+1];
					end
					shadow_count--;
				end
			end
			OP_GET: begin
				if (int'(c.pos) >= shadow_count)
					r.status = ST_RANGE;
				else begin
					r.id = shadow_ids[c.pos];
					r.size = shadow_sizes[c.pos];
				end
			end
			default: ;
		endcase
		r.fill = shadow_fill;
		r.count = COUNT_W'(shadow_count);
		predicted_replies.push_back(r);
	endtask

	task automatic queue_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [SIZE_W-1:0] size, input logic [POS_W-1:0] pos);
		set_cmd_t c;
		c.op = op;
		c.id = id;
		c.size = size;
		c.pos = pos;
		pending_ops.push_back(c);
	endtask

	function automatic logic [ID_W-1:0] draw_id();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return id_pool[$urandom_range(0, ID_POOL - 1)];
	endfunction

	function automatic logic [SIZE_W-1:0] draw_size(input int top);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SIZE_W'($urandom_range(0, 65535));
			default: return SIZE_W'($urandom_range(0, top));
		endcase
	endfunction

	// mostly runs of appends/removes on a small id pool so the set fills and drains
	task automatic make_traffic(input int n_words, input int size_top);
		int made;
		int pick;
		made = 0;
		while (made < n_words) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				for (int i = 0; i < 8; i++) begin
					pick = $urandom_range(0, 19);
					if (pick < 9)
						queue_cmd(OP_APPEND, draw_id(), draw_size(size_top),
							POS_W'($urandom));
					else if (pick < 14)
						queue_cmd(OP_REMOVE, draw_id(), SIZE_W'($urandom),
							POS_W'($urandom));
					else if (pick < 19)
						queue_cmd(OP_GET, $urandom, SIZE_W'($urandom), POS_W'($urandom));
					else
						queue_cmd(OP_SPARE, $urandom, SIZE_W'($urandom), POS_W'($urandom));
				end
				made += 8;
			end else if (pick < 8) begin
				for (int i = 0; i < 10; i++)
					queue_cmd(OP_APPEND, draw_id(), draw_size(size_top), POS_W'($urandom));
				made += 10;
			end else begin
				for (int i = 0; i < 8; i++)
					queue_cmd(OP_REMOVE, draw_id(), SIZE_W'($urandom), POS_W'($urandom));
				made += 8;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [SIZE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		shadow_capacity = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// driver: one word in flight, random gap after each word (none in every third run of 32 words)
	always @(posedge clk) begin : drive_proc
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				predict_reply(cur_cmd);
				nxt_valid = 1'b0;
				words_sent++;
			end
			if (!nxt_valid) begin
				if (gap_left > 0)
					gap_left--;
				else if (pending_ops.size() != 0) begin
					cur_cmd = pending_ops.pop_front();
					nxt_valid = 1'b1;
					gap_left = ((words_sent / 32) % 3 == 2) ? 0 : int'($urandom_range(0, 5));
				end
			end
			in_valid <= nxt_valid;
			operation <= cur_cmd.op;
			cell_id <= cur_cmd.id;
			cell_size <= cur_cmd.size;
			position <= cur_cmd.pos;
		end
	end

	// checker: compares each reply word with the oldest prediction
	always @(posedge clk) begin : check_proc
		set_reply_t got;
		set_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{status, found_id, found_size, fill_level, entry_count};
				if (predicted_replies.size() == 0) begin
					error_count++;
					if (error_count <= SHOW_LIMIT)
						$display("unexpected reply word: status %0d id %h size %0d fill %0d count %0d",
							got.status, got.id, got.size, got.fill, got.count);
				end else begin
					want = predicted_replies.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= SHOW_LIMIT) begin
							$display("reply %0d mismatch", replies_seen);
							$display("  expected: status %0d id %h size %0d fill %0d count %0d",
								want.status, want.id, want.size, want.fill, want.count);
							$display("  actual:   status %0d id %h size %0d fill %0d count %0d",
								got.status, got.id, got.size, got.fill, got.count);
						end
					end
				end
				replies_seen++;
				// one long hold-off so the block backs up and drops in_ready, else short random hold-offs or none
				if (replies_seen == HOLD_AT)
					ready_wait = HOLD_CYCLES;
				else if ((replies_seen / 40) % 3 == 1)
					ready_wait = 0;
				else
					ready_wait = int'($urandom_range(0, 5));
			end else if (ready_wait > 0)
				ready_wait--;
			out_ready <= (ready_wait == 0);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		id_pool[0] = '0;
		id_pool[1] = '1;
		id_pool[2] = 32'h8000_0000;
		for (int i = 3; i < ID_POOL; i++)
			id_pool[i] = $urandom;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_capacity(16'd1000);
		queue_cmd(OP_GET, '0, '0, '0);              // empty set, out of range
		queue_cmd(OP_REMOVE, 32'd5, '0, '0);        // absent id
		queue_cmd(OP_APPEND, '1, '0, '0);           // zero size, largest id
		queue_cmd(OP_APPEND, '0, 16'd1000, '0);     // fill reaches capacity exactly
		queue_cmd(OP_APPEND, 32'd7, 16'd1, '0);     // no room
		queue_cmd(OP_APPEND, '0, '0, '0);           // duplicate
		queue_cmd(OP_APPEND, '0, 16'd1, '0);        // room check wins over duplicate
		queue_cmd(OP_GET, '1, '1, 4'd0);
		queue_cmd(OP_GET, '0, '0, 4'd1);
		queue_cmd(OP_GET, '0, '0, '1);
		queue_cmd(OP_SPARE, 32'hA5A5_5A5A, '1, '1);
		queue_cmd(OP_REMOVE, '0, '1, '0);
		// descending ids force a shift on every insert, ends with all slots used
		for (int i = 15; i >= 1; i--)
			queue_cmd(OP_APPEND, ID_W'(i * 7), '0, '0);
		queue_cmd(OP_APPEND, 32'd1000, '0, '0);     // set full
		queue_cmd(OP_GET, '0, '0, 4'd15);
		queue_cmd(OP_REMOVE, 32'd49, '0, '0);
		wait_drained();

		set_capacity('1);
		make_traffic(140, 4000);
		wait_drained();

		set_capacity(SIZE_W'($urandom_range(500, 3000)));
		make_traffic(130, 600);
		wait_drained();

		// capacity below the held fill: appends fail until removes drain it, then only zero-size ones pass
		set_capacity('0);
		make_traffic(40, 50);
		wait_drained();

		set_capacity('1);
		make_traffic(90, 30000);
		wait_drained();

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
